// File: sv/rctp_pkg.sv
// Shared constants and the arctangent table for the cartesian to polar core.
package rctp_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int ATAN_ENTRIES = 32;
  localparam int NST = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_BITS = 33;
  localparam int CORDIC_LAT = 3 + SQRT_STEPS + 1 + DIV_BITS - 1;
  localparam int CW = 36;
  localparam int ZW = 32;

  localparam logic signed [ZW-1:0] PI_Q28 = 32'sd843314857;
  localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;

  function automatic logic signed [ZW-1:0] atan_q28(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 32'sd210828714;
      1: v = 32'sd124459457;
      2: v = 32'sd65760959;
      3: v = 32'sd33381290;
      4: v = 32'sd16755422;
      5: v = 32'sd8385879;
      6: v = 32'sd4193963;
      7: v = 32'sd2097109;
      8: v = 32'sd1048571;
      9: v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      24: v = 32'sd16;
      25: v = 32'sd8;
      26: v = 32'sd4;
      27: v = 32'sd2;
      28: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/rctp_cordic.sv
// Pipelined vectoring CORDIC that turns a position into its bearing.
module rctp_cordic (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  output logic signed [30:0] angle
);
  import rctp_pkg::*;

  localparam int DLY = CORDIC_LAT - NST - 2;

  logic signed [CW-1:0] cx [0:NST];
  logic signed [CW-1:0] cy [0:NST];
  logic signed [ZW-1:0] cz [0:NST];
  logic signed [30:0]   dl [0:DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (x_in < 0) begin
        if (y_in >= 0) begin
          cx[0] <= CW'(y_in);
          cy[0] <= -CW'(x_in);
          cz[0] <= HALF_PI_Q28;
        end else begin
          cx[0] <= -CW'(y_in);
          cy[0] <= CW'(x_in);
          cz[0] <= -HALF_PI_Q28;
        end
      end else begin
        cx[0] <= CW'(x_in);
        cy[0] <= CW'(y_in);
        cz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_q28(i);
        end else if (cy[i] < 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_q28(i);
        end else begin
          cx[i+1] <= cx[i];
          cy[i+1] <= cy[i];
          cz[i+1] <= cz[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cz[NST] > PI_Q28) begin
        dl[0] <= PI_Q28[30:0];
      end else if (cz[NST] < -PI_Q28) begin
        dl[0] <= -PI_Q28[30:0];
      end else begin
        dl[0] <= cz[NST][30:0];
      end
    end
  end

  for (genvar k = 0; k < DLY; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        dl[k+1] <= dl[k];
      end
    end
  end

  assign angle = dl[DLY];

endmodule

// File: sv/radar_cartesian_to_polar_core.sv
// Top level: range, bearing and range rate from a cartesian state vector.
//
//   channel | signals                          | direction
//   input   | in_valid in_ready pos_x pos_y vel_x vel_y | into the core
//   output  | out_valid out_ready range bearing range_rate zero_range | out of the core
//
// One beat enters per cycle while the output is not stalled; results leave in beat order.
// The latency is set by the 32-step square root and the 33-bit divider pipelines.
// Reset clears only the valid bits of the pipeline.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module radar_cartesian_to_polar_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        range,
  output logic signed [30:0] bearing,
  output logic signed [31:0] range_rate,
  output logic               zero_range
);
  import rctp_pkg::*;

  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  logic               va;
  logic signed [31:0] px, py, vx, vy;
  logic [31:0]        ax, ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= pos_x;
      py <= pos_y;
      vx <= vel_x;
      vy <= vel_y;
    end
  end

  assign ax = px[31] ? 32'(-px) : 32'(px);
  assign ay = py[31] ? 32'(-py) : 32'(py);

  logic               vb, zb;
  logic [63:0]        sqx, sqy;
  logic signed [63:0] p1, p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zb  <= (px == 0) && (py == 0);
      sqx <= ax * ax;
      sqy <= ay * ay;
      p1  <= px * vx;
      p2  <= py * vy;
    end
  end

  logic signed [64:0] dsum;
  assign dsum = {p1[63], p1} + {p2[63], p2};

  logic        sv_v    [0:SQRT_STEPS];
  logic        sv_z    [0:SQRT_STEPS];
  logic        sv_neg  [0:SQRT_STEPS];
  logic [63:0] sv_mag  [0:SQRT_STEPS];
  logic [63:0] sv_acc  [0:SQRT_STEPS];
  logic [63:0] sv_res  [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv_v[0] <= 1'b0;
    end else if (adv) begin
      sv_v[0] <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_z[0]   <= zb;
      sv_neg[0] <= dsum[64];
      sv_mag[0] <= dsum[64] ? 64'(-dsum) : dsum[63:0];
      sv_acc[0] <= sqx + sqy;
      sv_res[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = sv_res[j] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv_v[j+1] <= 1'b0;
      end else if (adv) begin
        sv_v[j+1] <= sv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sv_z[j+1]   <= sv_z[j];
        sv_neg[j+1] <= sv_neg[j];
        sv_mag[j+1] <= sv_mag[j];
        if (sv_acc[j] >= trial) begin
          sv_acc[j+1] <= sv_acc[j] - trial;
          sv_res[j+1] <= (sv_res[j] >> 1) + BIT;
        end else begin
          sv_acc[j+1] <= sv_acc[j];
          sv_res[j+1] <= sv_res[j] >> 1;
        end
      end
    end
  end

  logic [31:0] root;
  assign root = (sv_res[SQRT_STEPS] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                     : sv_res[SQRT_STEPS][31:0];

  logic                dv_v   [0:DIV_BITS];
  logic                dv_z   [0:DIV_BITS];
  logic                dv_neg [0:DIV_BITS];
  logic                dv_ovf [0:DIV_BITS];
  logic [31:0]         dv_r   [0:DIV_BITS];
  logic [63:0]         dv_rem [0:DIV_BITS];
  logic [DIV_BITS-1:0] dv_q   [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sv_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_z[0]   <= sv_z[SQRT_STEPS];
      dv_neg[0] <= sv_neg[SQRT_STEPS];
      dv_ovf[0] <= (sv_mag[SQRT_STEPS] >> DIV_BITS) >= 64'(root);
      dv_r[0]   <= root;
      dv_rem[0] <= sv_mag[SQRT_STEPS];
      dv_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - 1 - k;
    logic [64:0] dsh;
    assign dsh = {33'd0, dv_r[k]} << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_z[k+1]   <= dv_z[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_ovf[k+1] <= dv_ovf[k];
        dv_r[k+1]   <= dv_r[k];
        if ({1'b0, dv_rem[k]} >= dsh) begin
          dv_rem[k+1] <= dv_rem[k] - dsh[63:0];
          dv_q[k+1]   <= dv_q[k] | (DIV_BITS'(1) << B);
        end else begin
          dv_rem[k+1] <= dv_rem[k];
          dv_q[k+1]   <= dv_q[k];
        end
      end
    end
  end

  logic signed [30:0] angle;

  rctp_cordic u_cordic (
    .clk   (clk),
    .adv   (adv),
    .x_in  (px),
    .y_in  (py),
    .angle (angle)
  );

  logic [DIV_BITS-1:0] q;
  logic                qovf;
  logic signed [31:0]  rr;
  assign q = dv_q[DIV_BITS];
  assign qovf = dv_ovf[DIV_BITS];

  always_comb begin
    if (dv_neg[DIV_BITS]) begin
      if (qovf || q > 33'h0_8000_0000) begin
        rr = 32'sh8000_0000;
      end else begin
        rr = 32'(-q);
      end
    end else begin
      if (qovf || q > 33'h0_7FFF_FFFF) begin
        rr = 32'sh7FFF_FFFF;
      end else begin
        rr = q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_range <= dv_z[DIV_BITS];
      if (dv_z[DIV_BITS]) begin
        range      <= '0;
        bearing    <= '0;
        range_rate <= '0;
      end else begin
        range      <= dv_r[DIV_BITS];
        bearing    <= angle;
        range_rate <= rr;
      end
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench for the cartesian to polar core: random and directed beats checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        range;
  logic signed [30:0] bearing;
  logic signed [31:0] range_rate;
  logic               zero_range;

  typedef struct packed {
    logic [31:0]        range;
    logic signed [30:0] bearing;
    logic signed [31:0] range_rate;
    logic               zero_range;
  } polar_t;

  polar_t polar_q[$];
  int     errors;
  int     burst_left;

  localparam int NUM_STAGES = rctp_pkg::NST;
  localparam longint PI_VAL = 843314857;
  localparam longint HALF_PI_VAL = 421657428;

  radar_cartesian_to_polar_core uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
    .out_valid(out_valid), .out_ready(out_ready), .range(range),
    .bearing(bearing), .range_rate(range_rate), .zero_range(zero_range)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint angle_table(int i);
    longint tbl [0:31];
    tbl = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
            2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
            4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
    return tbl[i];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint xs;
    longint ys;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_VAL;
      end else begin
        x = -y; y = t; z = -HALF_PI_VAL;
      end
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + angle_table(i);
      end else if (y < 0) begin
        x = x - ys; y = y + xs; z = z - angle_table(i);
      end
    end
    if (z > PI_VAL) z = PI_VAL;
    if (z < -PI_VAL) z = -PI_VAL;
    return z;
  endfunction

  function automatic polar_t to_polar(logic signed [31:0] px, logic signed [31:0] py,
                                      logic signed [31:0] vx, logic signed [31:0] vy);
    polar_t      p;
    longint      lx, ly, p1, p2, s, rr;
    logic [63:0] ax, ay, r, mag, q;
    logic        neg;
    p = '0;
    if (px == 0 && py == 0) begin
      p.zero_range = 1'b1;
      return p;
    end
    lx = px;
    ly = py;
    ax = lx < 0 ? -lx : lx;
    ay = ly < 0 ? -ly : ly;
    r = int_sqrt(ax * ax + ay * ay);
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    p1 = lx * longint'(vx);
    p2 = ly * longint'(vy);
    if (p1 >= 0 && p2 >= 0) begin
      mag = p1 + p2; neg = 1'b0;
    end else if (p1 <= 0 && p2 <= 0) begin
      mag = (-p1) + (-p2); neg = 1'b1;
    end else begin
      s = p1 + p2;
      neg = s < 0;
      mag = neg ? -s : s;
    end
    q = mag / r;
    if (neg) rr = (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
    else rr = (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
    p.range = r[31:0];
    p.bearing = 31'(vector_angle(ly, lx));
    p.range_rate = rr[31:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("Mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_vector(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] vx, logic signed [31:0] vy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    vel_x <= vx;
    vel_y <= vy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    polar_q.push_back(to_polar(px, py, vx, vy));
  endtask

  always @(posedge clk) begin
    polar_t want;
    if (!rst && out_valid && out_ready) begin
      if (polar_q.size() == 0) begin
        $display("Unexpected result beat at %0t", $time);
        errors++;
      end else begin
        want = polar_q.pop_front();
        if (range !== want.range) report_mismatch("range", range, want.range);
        if (bearing !== want.bearing) report_mismatch("bearing", bearing, want.bearing);
        if (range_rate !== want.range_rate)
          report_mismatch("range_rate", range_rate, want.range_rate);
        if (zero_range !== want.zero_range)
          report_mismatch("zero_range", zero_range, want.zero_range);
      end
    end
  end

  always @(posedge clk) begin
    int phase;
    phase = ($time / 10) % 600;
    if (rst || phase < 150) out_ready <= 1'b1;
    else if (phase < 300) out_ready <= ($urandom_range(0, 3) != 0);
    else if (phase < 450) out_ready <= ($urandom_range(0, 1) == 0);
    else out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 19) != 0);
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      2: return 32'($signed(8'($urandom)));
      3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic test_extremes();
    send_vector(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vector(0, 0, 0, 0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
    send_vector(32'hFFFF_FFFF, 0, 32'h5555_5555, 32'hAAAA_AAAA);
    send_vector(0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_axes();
    send_vector(32'h0001_0000, 0, 32'h0002_0000, 0);
    send_vector(0, 32'h0001_0000, 0, 32'hFFFF_0000);
    send_vector(32'hFFFF_0000, 0, 32'h0001_0000, 32'h0001_0000);
    send_vector(32'h8000_0000, 0, 32'h0000_1000, 0);
    send_vector(0, 32'h8000_0000, 0, 32'h0000_1000);
    send_vector(32'hFFFF_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321);
    send_vector(32'hFFFF_0000, 32'h0000_0001, 32'h1234_5678, 32'h8765_4321);
  endtask

  task automatic test_rate_saturation();
    send_vector(1, 0, 32'h7FFF_FFFF, 0);
    send_vector(1, 0, 32'h8000_0000, 0);
    send_vector(32'hFFFF_FFFF, 0, 32'h8000_0000, 0);
    send_vector(1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(1, 1, 32'h8000_0000, 32'h8000_0000);
    send_vector(2, 32'hFFFF_FFFE, 32'h4000_0000, 32'hC000_0000);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (polar_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_vector(rand_word(), 0, rand_word(), rand_word());
      else if ($urandom_range(0, 19) == 0)
        send_vector(0, rand_word(), rand_word(), rand_word());
      else
        send_vector(rand_word(), rand_word(), rand_word(), rand_word());
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    pos_x = '0;
    pos_y = '0;
    vel_x = '0;
    vel_y = '0;
    errors = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_axes();
    test_rate_saturation();
    test_random(700);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && polar_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (polar_q.size() != 0) $display("%0d results never arrived", polar_q.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout at %0t", $time);
    $display("Verification failed");
    $finish;
  end

endmodule
